// ===== rtl/core/rsi_pkg.sv =====
// Shared constants for the ray-sphere intersection pipeline.
package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int DIST_W        = 31;
    localparam int DIR_W         = 18;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DISC_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIT_DIST   = 1'b1;

endpackage

// ===== rtl/core/rsi_in_if.sv =====
// Input channel: sphere, ray and nearest distance so far.
interface rsi_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rsi_pkg::COORD_W-1:0]  center_x;
    logic signed [rsi_pkg::COORD_W-1:0]  center_y;
    logic signed [rsi_pkg::COORD_W-1:0]  center_z;
    logic        [rsi_pkg::DIST_W-1:0]   sphere_radius;
    logic signed [rsi_pkg::COORD_W-1:0]  origin_x;
    logic signed [rsi_pkg::COORD_W-1:0]  origin_y;
    logic signed [rsi_pkg::COORD_W-1:0]  origin_z;
    logic signed [rsi_pkg::DIR_W-1:0]    dir_x;
    logic signed [rsi_pkg::DIR_W-1:0]    dir_y;
    logic signed [rsi_pkg::DIR_W-1:0]    dir_z;
    logic        [rsi_pkg::DIST_W-1:0]   nearest_in;

    modport source (
        output valid, center_x, center_y, center_z, sphere_radius,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_in,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, sphere_radius,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_in,
        output ready
    );
endinterface

// ===== rtl/core/rsi_out_if.sv =====
// Output channel: hit flag and updated nearest distance.
interface rsi_out_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [rsi_pkg::DIST_W-1:0]        nearest_out;

    modport source (output valid, hit, nearest_out, input ready);
    modport sink (input valid, hit, nearest_out, output ready);
endinterface

// ===== rtl/core/rsi_front.sv =====
// Front pipeline: difference vector, dot product, discriminant and threshold test.
module rsi_front #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    rsi_in_if.sink                        in_ch,
    input  logic [rsi_pkg::DIST_W-1:0]    disc_threshold,
    output logic                          valid_out,
    output logic [52-FRAC_BITS:0]         b_out,
    output logic [rsi_pkg::DIST_W-1:0]    near_out,
    output logic                          nohit_out,
    output logic [((2*(53-FRAC_BITS) > 69) ? 2*(53-FRAC_BITS) : 69)-1:0] d_out
);
    localparam int VW  = rsi_pkg::COORD_W + 1;
    localparam int PDW = VW + rsi_pkg::DIR_W;
    localparam int BSW = PDW + 2;
    localparam int BW  = BSW - FRAC_BITS;
    localparam int PVW = 2 * VW;
    localparam int RRW = 2 * rsi_pkg::DIST_W;
    localparam int VSW = PVW + 2;
    localparam int QW  = VSW + 1;
    localparam int LW  = BW / 2;
    localparam int HW  = BW - LW;
    localparam int BBW = 2 * BW;
    localparam int DW  = ((BBW > QW) ? BBW : QW) + 1;
    localparam int DPW = DW - 1;
    localparam int NST = 6;

    logic [NST-1:0] vld_reg;

    // stage 1
    logic signed [VW-1:0]             vx_reg, vy_reg, vz_reg;
    logic signed [rsi_pkg::DIR_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [rsi_pkg::DIST_W-1:0]       r_reg;
    logic [rsi_pkg::DIST_W-1:0]       near1_reg;
    // stage 2
    logic signed [PDW-1:0]            pdx_reg, pdy_reg, pdz_reg;
    logic signed [PVW-1:0]            pvx_reg, pvy_reg, pvz_reg;
    logic [RRW-1:0]                   rr_reg;
    logic [rsi_pkg::DIST_W-1:0]       near2_reg;
    // stage 3
    logic signed [BSW-1:0]            bsum;
    logic signed [VSW-1:0]            vsum;
    logic signed [BW-1:0]             b3_reg;
    logic signed [QW-1:0]             q3_reg;
    logic [rsi_pkg::DIST_W-1:0]       near3_reg;
    // stage 4
    logic [BW-1:0]                    mag;
    logic [2*HW-1:0]                  pp_hh_reg;
    logic [HW+LW-1:0]                 pp_hl_reg;
    logic [2*LW-1:0]                  pp_ll_reg;
    logic signed [BW-1:0]             b4_reg;
    logic signed [QW-1:0]             q4_reg;
    logic [rsi_pkg::DIST_W-1:0]       near4_reg;
    // stage 5
    logic [BBW-1:0]                   bb;
    logic signed [DW-1:0]             d_next;
    logic signed [DW-1:0]             d5_reg;
    logic signed [BW-1:0]             b5_reg;
    logic [rsi_pkg::DIST_W-1:0]       near5_reg;
    // stage 6
    logic signed [DW-1:0]             thr_ext;
    logic [DPW-1:0]                   d6_reg;
    logic signed [BW-1:0]             b6_reg;
    logic [rsi_pkg::DIST_W-1:0]       near6_reg;
    logic                             nohit6_reg;

    assign in_ch.ready = en;

    assign bsum    = pdx_reg + pdy_reg + pdz_reg;
    assign vsum    = pvx_reg + pvy_reg + pvz_reg;
    assign mag     = b3_reg[BW-1] ? BW'(-b3_reg) : BW'(b3_reg);
    assign bb      = (BBW'(pp_hh_reg) << (2 * LW)) + (BBW'(pp_hl_reg) << (LW + 1))
                   + BBW'(pp_ll_reg);
    assign d_next  = $signed(DW'(bb)) + DW'(q4_reg);
    assign thr_ext = $signed(DW'(disc_threshold) << FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg    <= VW'(in_ch.center_x) - VW'(in_ch.origin_x);
            vy_reg    <= VW'(in_ch.center_y) - VW'(in_ch.origin_y);
            vz_reg    <= VW'(in_ch.center_z) - VW'(in_ch.origin_z);
            dx_reg    <= in_ch.dir_x;
            dy_reg    <= in_ch.dir_y;
            dz_reg    <= in_ch.dir_z;
            r_reg     <= in_ch.sphere_radius;
            near1_reg <= in_ch.nearest_in;

            pdx_reg   <= PDW'(dx_reg) * PDW'(vx_reg);
            pdy_reg   <= PDW'(dy_reg) * PDW'(vy_reg);
            pdz_reg   <= PDW'(dz_reg) * PDW'(vz_reg);
            pvx_reg   <= PVW'(vx_reg) * PVW'(vx_reg);
            pvy_reg   <= PVW'(vy_reg) * PVW'(vy_reg);
            pvz_reg   <= PVW'(vz_reg) * PVW'(vz_reg);
            rr_reg    <= RRW'(r_reg) * RRW'(r_reg);
            near2_reg <= near1_reg;

            // floor shift
            b3_reg    <= bsum[BSW-1:FRAC_BITS];
            q3_reg    <= $signed(QW'(rr_reg)) - QW'(vsum);
            near3_reg <= near2_reg;

            pp_hh_reg <= (2*HW)'(mag[BW-1:LW]) * (2*HW)'(mag[BW-1:LW]);
            pp_hl_reg <= (HW+LW)'(mag[BW-1:LW]) * (HW+LW)'(mag[LW-1:0]);
            pp_ll_reg <= (2*LW)'(mag[LW-1:0]) * (2*LW)'(mag[LW-1:0]);
            b4_reg    <= b3_reg;
            q4_reg    <= q3_reg;
            near4_reg <= near3_reg;

            d5_reg    <= d_next;
            b5_reg    <= b4_reg;
            near5_reg <= near4_reg;

            nohit6_reg <= d5_reg < thr_ext;
            d6_reg     <= d5_reg[DW-1] ? '0 : d5_reg[DPW-1:0];
            b6_reg     <= b5_reg;
            near6_reg  <= near5_reg;
        end
    end

    assign valid_out = vld_reg[NST-1];
    assign b_out     = b6_reg;
    assign near_out  = near6_reg;
    assign nohit_out = nohit6_reg;
    assign d_out     = d6_reg;

endmodule

// ===== rtl/core/rsi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
module rsi_sqrt #(
    parameter int SQW    = 38,
    parameter int SIDE_W = 69
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  logic [2*SQW-1:0]    rad_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [SQW-1:0]      root_out,
    output logic [SIDE_W-1:0]   side_out
);
    localparam int RW = SQW + 3;

    logic [SQW-1:0]    vld_reg;
    logic [2*SQW-1:0]  rad_reg  [SQW];
    logic [RW-1:0]     rem_reg  [SQW];
    logic [SQW-1:0]    root_reg [SQW];
    logic [SIDE_W-1:0] side_reg [SQW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQW-2:0], valid_in};
        end
    end

    for (genvar k = 0; k < SQW; k++)
    begin : g_stage
        logic [2*SQW-1:0]  rad_cur;
        logic [RW-1:0]     rem_cur;
        logic [SQW-1:0]    root_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rad_cur  = rad_in;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_next
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign rem_sh = {rem_cur[RW-3:0], rad_cur[2*SQW-1 -: 2]};
        assign trial  = RW'({root_cur, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_cur << 2;
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_cur[SQW-2:0], ge};
                side_reg[k] <= side_cur;
            end
        end
    end

    assign valid_out = vld_reg[SQW-1];
    assign root_out  = root_reg[SQW-1];
    assign side_out  = side_reg[SQW-1];

`ifndef ASSERT_OFF
    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQW-1] |-> rem_reg[SQW-1] <= RW'({root_reg[SQW-1], 1'b0}))
        else $error("sqrt remainder out of bound");
    a_first_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> root_reg[0][SQW-1:1] == '0)
        else $error("first sqrt stage produced more than one bit");
`endif

endmodule

// ===== rtl/core/rsi_select.sv =====
// Root selection: tries near then far root and registers the result beat.
module rsi_select #(
    parameter int BW  = 37,
    parameter int SQW = 38
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [SQW-1:0]              root,
    input  logic [BW-1:0]               b,
    input  logic [rsi_pkg::DIST_W-1:0]  near,
    input  logic                        nohit,
    input  logic [rsi_pkg::DIST_W-1:0]  min_hit_distance,
    rsi_out_if.source                   out_ch
);
    localparam int TW = ((BW > SQW) ? BW : SQW) + 2;

    logic signed [TW-1:0]        b_ext, a_ext, t0, t1, mind_ext, near_ext;
    logic                        ok0, ok1;
    logic                        valid_reg;
    logic                        hit_reg;
    logic [rsi_pkg::DIST_W-1:0]  nearest_reg;

    assign b_ext    = TW'($signed(b));
    assign a_ext    = $signed(TW'(root));
    assign mind_ext = $signed(TW'(min_hit_distance));
    assign near_ext = $signed(TW'(near));
    assign t0       = b_ext - a_ext;
    assign t1       = b_ext + a_ext;
    assign ok0      = !nohit && (t0 > mind_ext) && (t0 < near_ext);
    assign ok1      = !nohit && (t1 > mind_ext) && (t1 < near_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (ok0)
            begin
                hit_reg     <= 1'b1;
                nearest_reg <= t0[rsi_pkg::DIST_W-1:0];
            end
            else if (ok1)
            begin
                hit_reg     <= 1'b1;
                nearest_reg <= t1[rsi_pkg::DIST_W-1:0];
            end
            else
            begin
                hit_reg     <= 1'b0;
                nearest_reg <= near;
            end
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.hit         = hit_reg;
    assign out_ch.nearest_out = nearest_reg;

endmodule

// ===== rtl/core/ray_sphere_intersect.sv =====
// Top level of the ray-sphere intersection pipeline.
//
// in_ch carries one sphere/ray pair and the nearest hit distance so far per
// beat; out_ch returns one beat per input beat, in order: hit and the
// updated nearest distance (unchanged when there is no hit).
// A beat is taken when valid and ready are both high.
// Throughput: one beat per cycle while the output is not stalled. SQW is the
// width of the square root (37 at 16 fraction bits); the pipeline has six
// front stages, one stage per root bit, and the output register.
// The pipeline advances as a whole whenever the output register is empty
// or being taken, so in_ch.ready follows out_ch.ready while a result waits;
// a stall freezes every stage and nothing is dropped or repeated.
// cfg_we/cfg_index/cfg_data write disc_threshold (index 0) and
// min_hit_distance (index 1); write them only while the pipeline is empty.
// Reset empties the pipeline and sets the thresholds to 0.01 and 0.1.
module ray_sphere_intersect #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rsi_in_if.sink                          in_ch,
    rsi_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsi_pkg::DIST_W-1:0]      cfg_data
);
    localparam int BW     = 53 - FRAC_BITS;
    localparam int DPW    = (2 * BW > 69) ? 2 * BW : 69;
    localparam int SQW    = (DPW + 1) / 2;
    localparam int SIDE_W = BW + rsi_pkg::DIST_W + 1;
    localparam logic [rsi_pkg::DIST_W-1:0] DISC_RST =
        rsi_pkg::DIST_W'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic [rsi_pkg::DIST_W-1:0] MIN_HIT_RST =
        rsi_pkg::DIST_W'(((1 << FRAC_BITS) + 5) / 10);

    logic                          adv;
    logic [rsi_pkg::DIST_W-1:0]    disc_thr_reg;
    logic [rsi_pkg::DIST_W-1:0]    min_hit_reg;

    logic                          f_valid;
    logic [BW-1:0]                 f_b;
    logic [rsi_pkg::DIST_W-1:0]    f_near;
    logic                          f_nohit;
    logic [DPW-1:0]                f_d;

    logic                          s_valid;
    logic [SQW-1:0]                s_root;
    logic [SIDE_W-1:0]             s_side;

    assign adv = !out_ch.valid || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_thr_reg <= DISC_RST;
            min_hit_reg  <= MIN_HIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rsi_pkg::CFG_DISC_THRESHOLD: disc_thr_reg <= cfg_data;
                rsi_pkg::CFG_MIN_HIT_DIST:   min_hit_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    rsi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .in_ch          (in_ch),
        .disc_threshold (disc_thr_reg),
        .valid_out      (f_valid),
        .b_out          (f_b),
        .near_out       (f_near),
        .nohit_out      (f_nohit),
        .d_out          (f_d)
    );

    rsi_sqrt #(
        .SQW    (SQW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (f_valid),
        .rad_in    ((2*SQW)'(f_d)),
        .side_in   ({f_b, f_near, f_nohit}),
        .valid_out (s_valid),
        .root_out  (s_root),
        .side_out  (s_side)
    );

    rsi_select #(
        .BW  (BW),
        .SQW (SQW)
    ) u_select (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (adv),
        .valid_in         (s_valid),
        .root             (s_root),
        .b                (s_side[SIDE_W-1 -: BW]),
        .near             (s_side[rsi_pkg::DIST_W:1]),
        .nohit            (s_side[0]),
        .min_hit_distance (min_hit_reg),
        .out_ch           (out_ch)
    );

`ifndef ASSERT_OFF
    a_hit_above_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.hit |-> out_ch.nearest_out > min_hit_reg)
        else $error("hit distance not above minimum");
`endif

endmodule
